>>> hdl/dsc_pkg.sv
// Shared constants, types and the modular add step of the divisible substring counter.
`timescale 1ns / 1ps
package dsc_pkg;

	localparam int DIGIT_W       = 4;
	localparam int POS_W         = 18;
	localparam int MOD_W         = 14;
	localparam int TOTAL_W       = 36;
	localparam int COUNT_W       = 19;
	localparam int EPOCH_W       = 8;
	localparam int IN_TDATA_W    = 24;
	localparam int OUT_TDATA_W   = 40;
	localparam int MOD_LIMIT_DEF = 16384;
	localparam int LENGTH_LIMIT  = 262144;
	localparam logic [MOD_W-1:0]   RESET_MODULUS = MOD_W'(3);
	localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX     = '1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST    = '1;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_CLEAR  = 10'b00_0000_0010,
		ST_RED_PF = 10'b00_0000_0100,
		ST_RED_SR = 10'b00_0000_1000,
		ST_MUL    = 10'b00_0001_0000,
		ST_ADD_SR = 10'b00_0010_0000,
		ST_PF10   = 10'b00_0100_0000,
		ST_ACC    = 10'b00_1000_0000,
		ST_FIN    = 10'b01_0000_0000,
		ST_SPARE  = 10'b10_0000_0000
	} state_t;

	// One step of the shared unit: (x + y + cin) mod m, with x, y below m.
	function automatic logic [MOD_W-1:0] addmod(input logic [MOD_W-1:0] x,
		input logic [MOD_W-1:0] y, input logic cin, input logic [MOD_W-1:0] m);
		logic [MOD_W:0] s;
		s = {1'b0, x} + {1'b0, y} + (MOD_W+1)'(cin);
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[MOD_W-1:0];
	endfunction

endpackage

>>> hdl/divisible_substring_counter.sv
// Top level of the divisible substring counter: sequencer, shared modular unit and remainder table.
`timescale 1ns / 1ps
// Digits of a decimal string enter one per beat, last digit first, each with its position
// from the start of the string; every beat returns the running count of substrings whose
// value divides by the configured modulus, and the beat at position 0 closes the string
// (tlast high) and clears the count. Modulus 2 or 5 uses the digit rule and goes from
// accept straight to the accumulate and finish steps. For any other modulus, one modular
// add-and-reduce unit is stepped by the sequencer 14 times to reduce the place factor,
// 14 times to reduce the suffix remainder, 8 times for factor times digit, once to add the
// suffix, and 4 times for the next factor (times ten), while the remainder table in block
// RAM is read and then written back. Table entries carry an 8-bit string tag, so closing a
// string costs nothing; after reset, and after every 256th string, a clearing pass sweeps
// all MOD_LIMIT table entries while s_axis_tready stays low (configuration writes are
// still taken). The modulus may be written at any time the block is idle; cfg_ready is
// always high.
module divisible_substring_counter
	import dsc_pkg::*;
#(
	parameter int MOD_LIMIT = MOD_LIMIT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [MOD_W-1:0]       cfg_data,      // modulus
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [3:0] digit, [21:4] position
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [35:0] total
	output logic                   m_axis_tlast   // done_res
);

	localparam int AW    = $clog2(MOD_LIMIT);
	localparam int CNT_W = $clog2(MOD_W);
	localparam int ENT_W = EPOCH_W + COUNT_W;

	state_t state_q;

	logic [MOD_W-1:0]   modulus_q;
	logic [MOD_W-1:0]   m_q;        // modulus in force for the current digit
	logic               fast_q;     // digit rule (modulus 2 or 5)
	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] dsh_q;      // digit bits, MSB consumed first
	logic [POS_W-1:0]   pos_q;
	logic               done_q;
	logic [TOTAL_W-1:0] total_q;
	logic [MOD_W-1:0]   place_q;
	logic [MOD_W-1:0]   suffix_q;
	logic [MOD_W-1:0]   src_q;      // value being reduced, shifted out MSB first
	logic [MOD_W-1:0]   acc_q;
	logic [MOD_W-1:0]   pf_q;
	logic [MOD_W-1:0]   sr_q;
	logic [MOD_W-1:0]   p2_q;
	logic [MOD_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]      clr_q;

	logic [ENT_W-1:0]   mem [MOD_LIMIT];
	logic [ENT_W-1:0]   rd_q;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [ENT_W-1:0]   mem_wd;

	logic [DIGIT_W-1:0] in_digit;
	logic [POS_W-1:0]   in_pos;
	logic [MOD_W-1:0]   m_eff;
	logic [MOD_W-1:0]   ux;
	logic [MOD_W-1:0]   uy;
	logic               ucin;
	logic [MOD_W-1:0]   ures;
	logic [COUNT_W-1:0] cnt_old;
	logic [COUNT_W-1:0] cnt_new;
	logic               div_hit;
	logic [TOTAL_W-1:0] add_v;
	logic               add_cin;
	logic [TOTAL_W:0]   sum_v;
	logic [TOTAL_W-1:0] total_next;
	logic               out_free;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_digit      = s_axis_tdata[DIGIT_W-1:0];
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	// Saturate position and bring the modulus into its legal range.
	always_comb begin
		in_pos = s_axis_tdata[DIGIT_W +: POS_W];
		if (int'(in_pos) >= LENGTH_LIMIT) begin
			in_pos = POS_W'(LENGTH_LIMIT - 1);
		end
		if (modulus_q == '0) begin
			m_eff = MOD_W'(1);
		end else if (int'(modulus_q) > MOD_LIMIT) begin
			m_eff = MOD_W'(MOD_LIMIT);
		end else begin
			m_eff = modulus_q;
		end
	end

	// Operand select for the shared add-and-reduce unit.
	always_comb begin
		ux   = acc_q;
		uy   = acc_q;
		ucin = 1'b0;
		case (state_q)
			ST_RED_PF, ST_RED_SR: begin
				ucin = src_q[MOD_W-1];
			end
			ST_MUL: begin
				if (cnt_q[0]) begin
					uy = dsh_q[DIGIT_W-1] ? pf_q : '0;
				end
			end
			ST_ADD_SR: begin
				uy = sr_q;
			end
			ST_PF10: begin
				if (cnt_q == '0) begin
					ux = pf_q;
					uy = pf_q;
				end else if (cnt_q == CNT_W'(3)) begin
					uy = p2_q;
				end
			end
			default: begin
				ux = acc_q;
			end
		endcase
		ures = addmod(ux, uy, ucin, m_q);
	end

	// Table entry and running-total update.
	always_comb begin
		cnt_old = (rd_q[ENT_W-1 -: EPOCH_W] == epoch_q) ? rd_q[COUNT_W-1:0] : '0;
		cnt_new = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + COUNT_W'(1);
		if (m_q == MOD_W'(2)) begin
			div_hit = !digit_q[0];
		end else begin
			div_hit = (digit_q == DIGIT_W'(0)) || (digit_q == DIGIT_W'(5)) ||
				(digit_q == DIGIT_W'(10)) || (digit_q == DIGIT_W'(15));
		end
		if (fast_q) begin
			add_v   = div_hit ? TOTAL_W'(pos_q) + TOTAL_W'(1) : '0;
			add_cin = 1'b0;
		end else begin
			add_v   = TOTAL_W'(cnt_old);
			add_cin = (rem_q == '0);
		end
		sum_v      = {1'b0, total_q} + {1'b0, add_v} + (TOTAL_W+1)'(add_cin);
		total_next = sum_v[TOTAL_W] ? TOTAL_MAX : sum_v[TOTAL_W-1:0];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = AW'(rem_q);
		mem_wd = {epoch_q, cnt_new};
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == ST_ACC && !fast_q) begin
			mem_we = 1'b1;
		end
	end

	// Remainder table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[AW'(rem_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= RESET_MODULUS;
		end else if (cfg_valid && cfg_ready) begin
			modulus_q <= cfg_data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			epoch_q       <= '0;
			total_q       <= '0;
			place_q       <= MOD_W'(1);
			suffix_q      <= '0;
			cnt_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MOD_LIMIT - 1)) begin
						epoch_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= (m_eff == MOD_W'(2) || m_eff == MOD_W'(5)) ? ST_ACC : ST_RED_PF;
					end
				end
				ST_RED_PF: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MOD_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_RED_SR;
					end
				end
				ST_RED_SR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MOD_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(2 * DIGIT_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_ADD_SR;
					end
				end
				ST_ADD_SR: begin
					state_q <= ST_PF10;
				end
				ST_PF10: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(3)) begin
						cnt_q   <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					total_q <= total_next;
					if (!fast_q) begin
						suffix_q <= rem_q;
						place_q  <= acc_q;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						state_q       <= ST_IDLE;
						if (done_q) begin
							total_q  <= '0;
							place_q  <= MOD_W'(1);
							suffix_q <= '0;
							if (epoch_q == EPOCH_LAST) begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end else begin
								epoch_q <= epoch_q + EPOCH_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; they follow the sequencer and need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				digit_q <= in_digit;
				dsh_q   <= in_digit;
				pos_q   <= in_pos;
				done_q  <= (in_pos == '0);
				m_q     <= m_eff;
				fast_q  <= (m_eff == MOD_W'(2) || m_eff == MOD_W'(5));
				src_q   <= place_q;
				acc_q   <= '0;
			end
			ST_RED_PF: begin
				acc_q <= ures;
				src_q <= src_q << 1;
				if (cnt_q == CNT_W'(MOD_W - 1)) begin
					pf_q  <= ures;
					acc_q <= '0;
					src_q <= suffix_q;
				end
			end
			ST_RED_SR: begin
				acc_q <= ures;
				src_q <= src_q << 1;
				if (cnt_q == CNT_W'(MOD_W - 1)) begin
					sr_q  <= ures;
					acc_q <= '0;
				end
			end
			ST_MUL: begin
				acc_q <= ures;
				if (cnt_q[0]) begin
					dsh_q <= dsh_q << 1;
				end
			end
			ST_ADD_SR: begin
				rem_q <= ures;
			end
			ST_PF10: begin
				acc_q <= ures;
				if (cnt_q == '0) begin
					p2_q <= ures;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					m_axis_tdata <= OUT_TDATA_W'(total_q);
					m_axis_tlast <= done_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted on two consecutive cycles");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the finish step");

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC && !fast_q |-> rem_q < m_q)
		else $error("suffix remainder not reduced below modulus");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |=> total_q >= $past(total_q))
		else $error("running total decreased within a string");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s_axis_tready && !mem_we || mem_wd == '0)
		else $error("table clearing pass overlapped item work");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the divisible substring counter: stream stimulus and scoreboard.
`timescale 1ns / 1ps

// Expected running totals, worked out beat by beat from the digits the block accepts.
class substring_tally;
	typedef struct packed {
		logic [dsc_pkg::TOTAL_W-1:0] total;
		logic                        last;
	} count_beat_t;

	logic [dsc_pkg::MOD_W-1:0]   modulus;
	logic [dsc_pkg::TOTAL_W-1:0] total;
	int unsigned                 factor;
	int unsigned                 suffix;
	int unsigned                 hits[int unsigned];
	count_beat_t                 awaited_totals[$];
	int                          errors;

	function new();
		modulus = dsc_pkg::RESET_MODULUS;
		errors  = 0;
		clear_string();
	endfunction

	function void clear_string();
		hits.delete();
		total  = '0;
		factor = 1;
		suffix = 0;
	endfunction

	function void set_modulus(logic [dsc_pkg::MOD_W-1:0] value);
		modulus = value;
	endfunction

	function logic [dsc_pkg::TOTAL_W-1:0] sat_sum(logic [dsc_pkg::TOTAL_W-1:0] a,
		longint unsigned b);
		longint unsigned s;
		s = longint'(a) + b;
		return (s > dsc_pkg::TOTAL_MAX) ? dsc_pkg::TOTAL_MAX : s[dsc_pkg::TOTAL_W-1:0];
	endfunction

	// Fold one accepted digit into the string state and queue the beat it must produce.
	function void note_digit(logic [dsc_pkg::DIGIT_W-1:0] digit,
		logic [dsc_pkg::POS_W-1:0] position);
		int unsigned m;
		int unsigned pf;
		int unsigned rem;
		int unsigned cnt;
		int unsigned pos;
		count_beat_t beat;
		m   = modulus;
		pos = position;
		if (m == 0) m = 1;
		if (m > dsc_pkg::MOD_LIMIT_DEF) m = dsc_pkg::MOD_LIMIT_DEF;
		if (pos >= dsc_pkg::LENGTH_LIMIT) pos = dsc_pkg::LENGTH_LIMIT - 1;
		if (m == 2 || m == 5) begin
			if (digit % m == 0) total = sat_sum(total, pos + 1);
		end else begin
			pf  = factor % m;
			rem = ((pf * digit) % m + suffix % m) % m;
			cnt = hits.exists(rem) ? hits[rem] : 0;
			if (rem == 0) total = sat_sum(total, 1);
			total = sat_sum(total, cnt);
			if (cnt < dsc_pkg::COUNT_MAX) cnt++;
			hits[rem] = cnt;
			suffix    = rem;
			factor    = (pf * 10) % m;
		end
		beat.total = total;
		beat.last  = (pos == 0);
		awaited_totals.push_back(beat);
		if (pos == 0) clear_string();
	endfunction

	function void check_beat(logic [dsc_pkg::TOTAL_W-1:0] got_total, logic got_last);
		count_beat_t want;
		if (awaited_totals.size() == 0) begin
			$display("%0t: unexpected result beat total %0d last %0b", $time, got_total,
				got_last);
			errors++;
			return;
		end
		want = awaited_totals.pop_front();
		if (got_total !== want.total) begin
			$display("%0t: total mismatch, expected %0d, actual %0d", $time, want.total,
				got_total);
			errors++;
		end
		if (got_last !== want.last) begin
			$display("%0t: tlast mismatch, expected %0b, actual %0b", $time, want.last,
				got_last);
			errors++;
		end
	endfunction
endclass

module testbench;
	import dsc_pkg::*;

	localparam int QUIET_LIMIT  = 60000;
	localparam int HOLD_AT      = 700;
	localparam int HOLD_CYCLES  = 3000;
	localparam int PHASES       = 17;
	localparam int PHASE_DIGITS = 44;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [MOD_W-1:0]       cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	substring_tally tally = new();
	int             send_idle_pct = 26;
	int             recv_idle_pct = 81;
	int             digits_sent = 0;
	int             beats_taken = 0;
	int             hold_left = 0;
	bit             held = 1'b0;
	int             quiet_cycles = 0;

	divisible_substring_counter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Result side: check each beat, throttle tready, and hold off once for a long stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				tally.check_beat(m_axis_tdata[TOTAL_W-1:0], m_axis_tlast);
				beats_taken++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!held && beats_taken >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Abort when nothing moves on any channel for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one digit beat, idling first at the current rate; tvalid stays high afterwards.
	task automatic send_digit(input logic [DIGIT_W-1:0] digit, input logic [POS_W-1:0] pos);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, pos, digit};
		do @(posedge clk); while (!s_axis_tready);
		digits_sent++;
		tally.note_digit(digit, pos);
	endtask

	// Drop tvalid and hold until every queued total has come back.
	task automatic await_drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (tally.awaited_totals.size() != 0);
	endtask

	task automatic write_modulus(input logic [MOD_W-1:0] value);
		await_drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tally.set_modulus(value);
	endtask

	// A well-formed string: positions count down to zero, mostly decimal digits.
	task automatic send_string(input int len);
		logic [DIGIT_W-1:0] d;
		for (int i = len - 1; i >= 0; i--) begin
			d = ($urandom_range(19) == 0) ? DIGIT_W'($urandom_range(15)) :
				DIGIT_W'($urandom_range(9));
			send_digit(d, POS_W'(i));
		end
	endtask

	initial begin
		logic [MOD_W-1:0] mods [PHASES];
		logic [POS_W-1:0] start;
		int               target;
		int               kind;
		int               len;
		int               k;

		mods = '{3, 7, 2, 11, 5, 1, 0, 16383, 9973, 10000, 13, 4, 6, 9, 8, 0, 0};
		mods[15] = MOD_W'($urandom_range(64, 2));
		mods[16] = MOD_W'($urandom_range(16383));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset modulus 3 on a plain string, then a lone zero digit.
		send_digit(4'd6, 18'd3);
		send_digit(4'd3, 18'd2);
		send_digit(4'd2, 18'd1);
		send_digit(4'd1, 18'd0);
		send_digit(4'd0, 18'd0);
		// Highest position, digits above nine.
		send_digit(4'd9, 18'h3FFFF);
		send_digit(4'd15, 18'd131072);
		send_digit(4'd10, 18'd0);
		// Digit rule for 2 and 5, with the largest position.
		write_modulus(MOD_W'(2));
		send_digit(4'd8, 18'h3FFFF);
		send_digit(4'd3, 18'd5);
		send_digit(4'd0, 18'd0);
		write_modulus(MOD_W'(5));
		send_digit(4'd5, 18'd2);
		send_digit(4'd0, 18'd1);
		send_digit(4'd7, 18'd0);
		// Modulus zero acts as one; then the widest modulus.
		write_modulus(MOD_W'(0));
		send_digit(4'd4, 18'd1);
		send_digit(4'd4, 18'd0);
		write_modulus(MOD_W'(16383));
		send_digit(4'd9, 18'd2);
		send_digit(4'd9, 18'd1);
		send_digit(4'd9, 18'd0);
		// Modulus changes in the middle of a string.
		write_modulus(MOD_W'(7));
		send_digit(4'd1, 18'd3);
		send_digit(4'd4, 18'd2);
		write_modulus(MOD_W'(10));
		send_digit(4'd0, 18'd1);
		send_digit(4'd5, 18'd0);

		// Random phases: one modulus each, idling shifts from sender-light to receiver-light
		// to none.
		for (int i = 0; i < PHASES; i++) begin
			if (i < 6) begin
				send_idle_pct = 26;
				recv_idle_pct = 81;
			end else if (i < 12) begin
				send_idle_pct = 81;
				recv_idle_pct = 26;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_modulus(mods[i]);
			// Burst of one-digit strings to roll the string tag over.
			if (i == 9) begin
				repeat (300) send_digit(DIGIT_W'($urandom_range(9)), '0);
			end
			target = digits_sent + PHASE_DIGITS;
			while (digits_sent < target) begin
				kind = $urandom_range(99);
				if (kind < 70) begin
					len = $urandom_range(99);
					if (len < 30) len = 1;
					else if (len < 90) len = $urandom_range(20, 2);
					else len = $urandom_range(120, 21);
					send_string(len);
				end else if (kind < 85) begin
					// Broken string: starts anywhere, jumps to zero after a few digits.
					start = POS_W'($urandom_range(262143));
					k = $urandom_range(5, 1);
					for (int j = 0; j < k; j++) begin
						send_digit(DIGIT_W'($urandom_range(15)), start - POS_W'(j));
					end
					send_digit(DIGIT_W'($urandom_range(15)), '0);
				end else begin
					k = $urandom_range(4, 1);
					repeat (k) begin
						send_digit(DIGIT_W'($urandom_range(15)),
							($urandom_range(3) == 0) ? '0 : POS_W'($urandom_range(262143)));
					end
				end
			end
		end

		await_drain();
		repeat (100) @(posedge clk);
		if (tally.errors == 0 && tally.awaited_totals.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
